[rtl/nrlh_pkg.sv]
// shared types, constants and helpers for the nsec3 random label hasher
package nrlh_pkg;

	localparam int MAX_DOMAIN_BYTES = 32;
	localparam int MAX_SALT_BYTES = 8;

	typedef logic [15:0][31:0] msg_block_t;
	typedef logic [159:0] digest_t;

	localparam logic [31:0] SHA_H0 = 32'h67452301;
	localparam logic [31:0] SHA_H1 = 32'hEFCDAB89;
	localparam logic [31:0] SHA_H2 = 32'h98BADCFE;
	localparam logic [31:0] SHA_H3 = 32'h10325476;
	localparam logic [31:0] SHA_H4 = 32'hC3D2E1F0;

	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [7:0] LABEL_LEN = 8'd8;

	// configuration register indexes
	localparam logic [2:0] REG_ITER = 3'd0;
	localparam logic [2:0] REG_SALT_LEN = 3'd1;
	localparam logic [2:0] REG_SALT = 3'd2;
	localparam logic [2:0] REG_DOM_LEN = 3'd3;
	localparam logic [2:0] REG_DOM0 = 3'd4;
	localparam logic [2:0] REG_DOM1 = 3'd5;
	localparam logic [2:0] REG_DOM2 = 3'd6;
	localparam logic [2:0] REG_DOM3 = 3'd7;

	function automatic logic [7:0] letter_of(input logic [3:0] sel);
		logic [7:0] ch;
		case (sel)
			4'd0: ch = "e";
			4'd1: ch = "t";
			4'd2: ch = "a";
			4'd3: ch = "o";
			4'd4: ch = "i";
			4'd5: ch = "n";
			4'd6: ch = "s";
			4'd7: ch = "h";
			4'd8: ch = "r";
			4'd9: ch = "d";
			4'd10: ch = "l";
			4'd11: ch = "u";
			4'd12: ch = "c";
			4'd13: ch = "m";
			4'd14: ch = "f";
			default: ch = "w";
		endcase
		return ch;
	endfunction

endpackage

[rtl/nrlh_sha1_core.sv]
// iterative sha-1 compression of one block, one round per cycle
module nrlh_sha1_core import nrlh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  msg_block_t block,
	output logic       done,
	output digest_t    digest
);

	logic [6:0] round_q;
	logic       run_q;
	logic       fin_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [15:0][31:0] w_q;
	logic [31:0] f, k, t, w_next;

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		w_next = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_next = {w_next[30:0], w_next[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			fin_q <= 1'b0;
			if (start && !run_q && !fin_q) begin
				run_q <= 1'b1;
				round_q <= '0;
			end else if (run_q) begin
				round_q <= round_q + 7'd1;
				if (round_q == 7'd79) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				done <= 1'b1;
				round_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !run_q && !fin_q) begin
			// schedule held as a sliding window, w_q[0] is this round's word
			for (int j = 0; j < 16; j++) begin
				w_q[j] <= block[j];
			end
			a_q <= SHA_H0;
			b_q <= SHA_H1;
			c_q <= SHA_H2;
			d_q <= SHA_H3;
			e_q <= SHA_H4;
		end else if (run_q) begin
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j + 1];
			end
			w_q[15] <= w_next;
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end else if (fin_q) begin
			digest <= {SHA_H0 + a_q, SHA_H1 + b_q, SHA_H2 + c_q, SHA_H3 + d_q, SHA_H4 + e_q};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) round_q <= 7'd80)
		else $error("round counter past last round");
	assert property (@(posedge clk) disable iff (!arst_n) !(run_q && fin_q))
		else $error("core running and finishing at once");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(fin_q))
		else $error("done without a finishing cycle");

endmodule

[rtl/nsec3_random_label_hasher.sv]
// nsec3 random label hasher: builds a salted dns name and iterates sha-1 over it
//
// a request is taken when start is high and busy is low; random_word picks the
// eight label letters, lowest nibble first. the block then writes the wire
// format name plus salt into a one-block message buffer, one byte a cycle,
// and runs the sha-1 core over it: its rounds, a finishing add and the hand-off.
// each of the iteration_count rehashes then hashes the digest plus salt as a
// block of its own, so a request hashes one block more than iteration_count;
// the lengths used are those after saturation. busy stays high until the
// result is out. the digest and label appear on the result ports for exactly
// one cycle with done high; the receiver cannot stall, and a new request may
// be given in that cycle. configuration is written on cfg_valid / cfg_ready
// (ready is always high) and should only change while busy is low. reset
// clears the sequencer and puts the registers to their defaults
// (domain_length 1, all others zero).
module nsec3_random_label_hasher import nrlh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] random_word,
	output logic        done,
	output logic [63:0] digest_high,
	output logic [63:0] digest_middle,
	output logic [31:0] digest_low,
	output logic [63:0] label_text,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DOM  = 7'b0000010,
		ST_TERM = 7'b0000100,
		ST_SALT = 7'b0001000,
		ST_PAD  = 7'b0010000,
		ST_HASH = 7'b0100000,
		ST_WAIT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [11:0] iter_q;
	logic [3:0] salt_len_q;
	logic [63:0] salt_q;
	logic [5:0] dom_len_q;
	logic [255:0] dom_q;
	msg_block_t msg_q;
	logic [5:0] idx_q, pos_q, len_pos_q, count_q;
	logic [11:0] rehash_q;
	logic [5:0] dlen;
	logic [3:0] slen;
	logic [7:0] dom_byte, salt_byte;
	logic sha_start, sha_done;
	digest_t sha_digest;
	msg_block_t rehash_blk;
	logic [63:0] label;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign dlen = (dom_len_q > 6'(MAX_DOMAIN_BYTES)) ? 6'(MAX_DOMAIN_BYTES) : dom_len_q;
	assign slen = (salt_len_q > 4'(MAX_SALT_BYTES)) ? 4'(MAX_SALT_BYTES) : salt_len_q;
	assign dom_byte = dom_q[8'd255 - {idx_q[4:0], 3'b000} -: 8];
	assign salt_byte = salt_q[6'd63 - {idx_q[2:0], 3'b000} -: 8];
	assign sha_start = (state_q == ST_HASH);

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			label[63 - 8 * j -: 8] = letter_of(random_word[4 * j +: 4]);
		end
	end

	// rehash message: digest, salt, pad byte, bit length
	always_comb begin
		rehash_blk = '0;
		for (int j = 0; j < 5; j++) begin
			rehash_blk[j] = sha_digest[159 - 32 * j -: 32];
		end
		for (int j = 0; j < 12; j++) begin
			if (4'(j) < slen) begin
				rehash_blk[5 + j / 4][31 - 8 * (j % 4) -: 8] = salt_q[63 - 8 * j -: 8];
			end else if (4'(j) == slen) begin
				rehash_blk[5 + j / 4][31 - 8 * (j % 4) -: 8] = PAD_BYTE;
			end
		end
		rehash_blk[15] = {23'd0, 6'd20 + {2'b00, slen}, 3'b000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			salt_len_q <= '0;
			salt_q <= '0;
			dom_len_q <= 6'd1;
			dom_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ITER: iter_q <= cfg_data[11:0];
				REG_SALT_LEN: salt_len_q <= cfg_data[3:0];
				REG_SALT: salt_q <= cfg_data;
				REG_DOM_LEN: dom_len_q <= cfg_data[5:0];
				REG_DOM0: dom_q[255:192] <= cfg_data;
				REG_DOM1: dom_q[191:128] <= cfg_data;
				REG_DOM2: dom_q[127:64] <= cfg_data;
				REG_DOM3: dom_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			len_pos_q <= '0;
			count_q <= '0;
			rehash_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DOM;
						idx_q <= '0;
						pos_q <= 6'd10;
						len_pos_q <= 6'd9;
						count_q <= '0;
						rehash_q <= '0;
					end
				end
				ST_DOM: begin
					if (idx_q == dlen) begin
						state_q <= ST_TERM;
					end else begin
						idx_q <= idx_q + 6'd1;
						pos_q <= pos_q + 6'd1;
						if (dom_byte == DOT_CHAR) begin
							len_pos_q <= pos_q;
							count_q <= '0;
						end else begin
							count_q <= count_q + 6'd1;
						end
					end
				end
				ST_TERM: begin
					// terminating zero byte is already clear
					pos_q <= pos_q + 6'd1;
					idx_q <= '0;
					state_q <= ST_SALT;
				end
				ST_SALT: begin
					if (idx_q[3:0] == slen) begin
						state_q <= ST_PAD;
					end else begin
						idx_q <= idx_q + 6'd1;
						pos_q <= pos_q + 6'd1;
					end
				end
				ST_PAD: state_q <= ST_HASH;
				ST_HASH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sha_done) begin
						if (rehash_q == iter_q) begin
							done <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							rehash_q <= rehash_q + 12'd1;
							state_q <= ST_HASH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					msg_q <= {416'd0, label[7:0], 24'd0, label[39:8], LABEL_LEN, label[63:40]};
					label_text <= label;
				end
			end
			ST_DOM: begin
				if (idx_q != dlen) begin
					if (dom_byte == DOT_CHAR) begin
						msg_q[len_pos_q[5:2]][{~len_pos_q[1:0], 3'b000} +: 8] <= {2'b00, count_q};
					end else begin
						msg_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= dom_byte;
					end
				end
			end
			ST_TERM: msg_q[len_pos_q[5:2]][{~len_pos_q[1:0], 3'b000} +: 8] <= {2'b00, count_q};
			ST_SALT: begin
				if (idx_q[3:0] != slen) begin
					msg_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= salt_byte;
				end else begin
					// message length in bits, pos_q holds the pad position here
					msg_q[15] <= {23'd0, pos_q, 3'b000};
				end
			end
			ST_PAD: msg_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= PAD_BYTE;
			ST_WAIT: begin
				if (sha_done) begin
					msg_q <= rehash_blk;
					digest_high <= sha_digest[159:96];
					digest_middle <= sha_digest[95:32];
					digest_low <= sha_digest[31:0];
				end
			end
			default: ;
		endcase
	end

	nrlh_sha1_core u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start),
		.block  (msg_q),
		.done   (sha_done),
		.digest (sha_digest)
	);

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result without a request in progress");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request accepted but block not busy");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("still busy when result is shown");
	assert property (@(posedge clk) disable iff (!arst_n) rehash_q <= iter_q || !busy)
		else $error("rehash count ran past iteration count");

endmodule

[tb/nrlh_checker.sv]
// checker for the nsec3 label hasher: predicts each digest and compares results
`timescale 1ns / 1ps

module nrlh_checker import nrlh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] random_word,
	input  logic        done,
	input  logic [63:0] digest_high,
	input  logic [63:0] digest_middle,
	input  logic [31:0] digest_low,
	input  logic [63:0] label_text,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef logic [0:63][7:0] wire_msg_t;

	typedef struct packed {
		logic [63:0] dig_hi;
		logic [63:0] dig_mid;
		logic [31:0] dig_lo;
		logic [63:0] label;
	} hash_result_t;

	localparam logic [0:15][7:0] LETTERS = "etaoinshrdlucmfw";

	logic [11:0] iter_cfg = '0;
	logic [3:0]  salt_len_cfg = '0;
	logic [63:0] salt_cfg = '0;
	logic [5:0]  dom_len_cfg = 6'd1;
	logic [63:0] dom_word [4] = '{default: '0};

	hash_result_t expected_digests [$];

	assign pending = expected_digests.size();

	function automatic digest_t sha1_once(input wire_msg_t m, input int unsigned len);
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		logic [15:0] bits;
		int s;
		m[len] = PAD_BYTE;
		bits = 16'(len * 8);
		m[62] = bits[15:8];
		m[63] = bits[7:0];
		for (int i = 0; i < 16; i++)
			w[i] = {m[4*i], m[4*i+1], m[4*i+2], m[4*i+3]};
		a = SHA_H0; b = SHA_H1; c = SHA_H2; d = SHA_H3; e = SHA_H4;
		for (int r = 0; r < 80; r++) begin
			s = r & 15;
			if (r >= 16) begin
				t = w[(s+13)&15] ^ w[(s+8)&15] ^ w[(s+2)&15] ^ w[s];
				w[s] = {t[30:0], t[31]};
			end
			if (r < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[s];
			e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
		end
		return {SHA_H0 + a, SHA_H1 + b, SHA_H2 + c, SHA_H3 + d, SHA_H4 + e};
	endfunction

	function automatic hash_result_t hash_label(input logic [31:0] rnd);
		wire_msg_t msg, rh;
		digest_t dg;
		hash_result_t res;
		int n, len_pos, cnt, dlen, slen;
		logic [7:0] ch;
		msg = '0;
		n = 0;
		res.label = '0;
		dlen = (dom_len_cfg > MAX_DOMAIN_BYTES) ? MAX_DOMAIN_BYTES : dom_len_cfg;
		slen = (salt_len_cfg > MAX_SALT_BYTES) ? MAX_SALT_BYTES : salt_len_cfg;
		msg[n++] = LABEL_LEN;
		for (int i = 0; i < 8; i++) begin
			ch = LETTERS[rnd[4*i +: 4]];
			msg[n++] = ch;
			res.label = {res.label[55:0], ch};
		end
		len_pos = n++;
		cnt = 0;
		for (int i = 0; i < dlen; i++) begin
			ch = dom_word[i >> 3][63 - 8*(i & 7) -: 8];
			if (ch == DOT_CHAR) begin
				msg[len_pos] = 8'(cnt);
				len_pos = n++;
				cnt = 0;
			end else begin
				msg[n++] = ch;
				cnt++;
			end
		end
		msg[len_pos] = 8'(cnt);
		msg[n++] = 8'h00;
		rh = '0;
		for (int i = 0; i < slen; i++) begin
			msg[n++] = salt_cfg[63 - 8*i -: 8];
			rh[20 + i] = salt_cfg[63 - 8*i -: 8];
		end
		dg = sha1_once(msg, n);
		for (int r = 0; r < iter_cfg; r++) begin
			for (int i = 0; i < 20; i++)
				rh[i] = dg[159 - 8*i -: 8];
			dg = sha1_once(rh, 20 + slen);
		end
		res.dig_hi = dg[159:96];
		res.dig_mid = dg[95:32];
		res.dig_lo = dg[31:0];
		return res;
	endfunction

	always @(posedge clk) begin
		hash_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ITER:     iter_cfg = cfg_data[11:0];
					REG_SALT_LEN: salt_len_cfg = cfg_data[3:0];
					REG_SALT:     salt_cfg = cfg_data;
					REG_DOM_LEN:  dom_len_cfg = cfg_data[5:0];
					REG_DOM0:     dom_word[0] = cfg_data;
					REG_DOM1:     dom_word[1] = cfg_data;
					REG_DOM2:     dom_word[2] = cfg_data;
					REG_DOM3:     dom_word[3] = cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (expected_digests.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = expected_digests.pop_front();
					if (digest_high !== want.dig_hi) begin
						$error("digest_high: expected %h, got %h", want.dig_hi, digest_high);
						fail_count++;
					end
					if (digest_middle !== want.dig_mid) begin
						$error("digest_middle: expected %h, got %h", want.dig_mid, digest_middle);
						fail_count++;
					end
					if (digest_low !== want.dig_lo) begin
						$error("digest_low: expected %h, got %h", want.dig_lo, digest_low);
						fail_count++;
					end
					if (label_text !== want.label) begin
						$error("label_text: expected %h, got %h", want.label, label_text);
						fail_count++;
					end
				end
			end
			// request taken at this edge
			if (start && !busy)
				expected_digests.push_back(hash_label(random_word));
		end
	end

endmodule

[tb/tb_nsec3_random_label_hasher.sv]
// top of the nsec3 label hasher testbench: stimulus, configuration and verdict
`timescale 1ns / 1ps

module tb_nsec3_random_label_hasher;
	import nrlh_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] random_word = '0;
	logic        done;
	logic [63:0] digest_high, digest_middle, label_text;
	logic [31:0] digest_low;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_ITER;
	logic [63:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          idle_pct;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	nsec3_random_label_hasher u_dut (
		.clk, .arst_n, .start, .busy, .random_word, .done,
		.digest_high, .digest_middle, .digest_low, .label_text,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	nrlh_checker u_checker (
		.clk, .arst_n, .start, .busy, .random_word, .done,
		.digest_high, .digest_middle, .digest_low, .label_text,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .pending
	);

	task automatic send_request(input logic [31:0] w);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 120)) @(posedge clk);
		end
		start <= 1'b1;
		random_word <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_domain(input logic [5:0] len, input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3);
		write_reg(REG_DOM_LEN, {58'd0, len});
		write_reg(REG_DOM0, w0);
		write_reg(REG_DOM1, w1);
		write_reg(REG_DOM2, w2);
		write_reg(REG_DOM3, w3);
	endtask

	task automatic set_salt(input logic [11:0] iters, input logic [3:0] slen, input logic [63:0] s);
		write_reg(REG_ITER, {52'd0, iters});
		write_reg(REG_SALT_LEN, {60'd0, slen});
		write_reg(REG_SALT, s);
	endtask

	// mix of dots, lowercase letters and arbitrary bytes
	function automatic logic [63:0] rand_domain_word();
		logic [63:0] w;
		int pick;
		for (int i = 0; i < 8; i++) begin
			pick = $urandom_range(9);
			if (pick < 2) w[8*i +: 8] = DOT_CHAR;
			else if (pick < 8) w[8*i +: 8] = 8'("a") + 8'($urandom_range(25));
			else w[8*i +: 8] = 8'($urandom);
		end
		return w;
	endfunction

	initial begin
		#80_000_000;
		$display("** nsec3_random_label_hasher: FAILED **");
		$finish;
	end

	initial begin
		logic [63:0] rnd_data;
		idle_pct = 10;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: one domain byte of zero, no salt, no rehash
		send_request(32'h0000_0000);
		send_request(32'hFFFF_FFFF);
		send_request(32'h7654_3210);
		send_request(32'hFEDC_BA98);
		wait_drained();

		set_domain(6'd11, "example.", "com\0\0\0\0\0", '0, '0);
		set_salt(12'd1, 4'd8, 64'hAABB_CCDD_EEFF_0011);
		send_request(32'h0F0F_0F0F);
		send_request(32'hF0F0_F0F0);
		wait_drained();

		// empty domain
		set_domain(6'd0, '0, '0, '0, '0);
		set_salt(12'd2, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(32'h1234_5678);
		send_request(32'h9ABC_DEF0);
		wait_drained();

		// oversized lengths saturate; leading, trailing and repeated dots
		set_domain(6'd63, ".ab..cd.", "efghijkl", "m.nopqr.", "stuvwxy.");
		set_salt(12'd0, 4'd15, 64'h0123_4567_89AB_CDEF);
		send_request(32'hA5A5_A5A5);
		send_request(32'h5A5A_5A5A);
		wait_drained();
		write_reg(REG_DOM_LEN, 64'd32);
		send_request(32'hDEAD_BEEF);
		wait_drained();

		// full count of rehashes, once
		set_salt(12'hFFF, 4'd8, 64'h8000_0000_0000_0001);
		send_request(32'hC0FF_EE00);
		wait_drained();
		write_reg(REG_ITER, 64'd2500);
		write_reg(REG_ITER, 64'd0);

		for (int phase = 0; phase < 10; phase++) begin
			idle_pct = (phase < 4) ? 10 : (phase < 8) ? 52 : 0;
			rnd_data = {$urandom, $urandom};
			set_domain(6'($urandom_range(63)), rand_domain_word(), rand_domain_word(),
				rand_domain_word(), rand_domain_word());
			set_salt(12'($urandom_range(3)), 4'($urandom_range(15)), rnd_data);
			for (int n = 0; n < 64; n++) begin
				send_request($urandom);
				// let outstanding requests drain before the next request
				if (n == 32 && phase == 5) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("** nsec3_random_label_hasher: PASSED **");
		else
			$display("** nsec3_random_label_hasher: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
rtl/nrlh_pkg.sv
rtl/nrlh_sha1_core.sv
rtl/nsec3_random_label_hasher.sv
tb/nrlh_checker.sv
tb/tb_nsec3_random_label_hasher.sv
